### sv/deq_pkg.sv
// types, codes and constants shared by the delayed effect queue
`default_nettype none

package deq_pkg;

	localparam int DEQ_QUEUE_DEPTH = 16;

	localparam logic [30:0] STEP_MAX = 31'h7fff_ffff;
	localparam logic [31:0] FIRST_ID = 32'd1;

	localparam logic [1:0] MODE_SCHEDULE = 2'd0;
	localparam logic [1:0] MODE_TICK     = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;

	localparam logic [1:0] KIND_ECHO  = 2'd0;
	localparam logic [1:0] KIND_APPLY = 2'd1;
	localparam logic [1:0] KIND_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [30:0]        current_step;
		logic signed [15:0] delay_steps;
		logic [15:0]        source_tag;
		logic [63:0]        payload;
		logic               is_external;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] eff_id;
		logic [30:0] step_stamp;
		logic [30:0] due_at;
		logic [15:0] out_source_tag;
		logic [63:0] out_payload;
		logic        out_external;
		logic        last;
		logic [4:0]  pending_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] id;
		logic [30:0] due;
		logic [15:0] source;
		logic [63:0] payload;
		logic        external;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic shift;
		logic keep_head;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### sv/deq_cell.sv
// one slot of the entry chain: holds an entry and takes its neighbor's on a shift
`default_nettype none

module deq_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire deq_pkg::cell_ctl_t ctl,
	input  wire logic               prev_valid,
	input  wire logic               next_valid,
	input  wire deq_pkg::entry_t    next_entry,
	input  wire deq_pkg::entry_t    head_entry,
	input  wire deq_pkg::entry_t    new_entry,
	output logic                    valid,
	output deq_pkg::entry_t         entry
);
	import deq_pkg::*;

	logic   valid_q;
	entry_t entry_q;
	logic   take_head;
	logic   load_here;

	// the old tail slot receives a kept head entry
	assign take_head = valid_q && !next_valid && ctl.keep_head;
	// the first free slot receives a new entry
	assign load_here = ctl.load && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			if (!take_head) begin
				valid_q <= next_valid;
			end
		end else if (load_here) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= take_head ? head_entry : next_entry;
		end else if (load_here) begin
			entry_q <= new_entry;
		end
	end

	assign valid = valid_q;
	assign entry = entry_q;

endmodule

`default_nettype wire

### sv/deq_ctrl.sv
// sequencer: schedule, tick scan and emit passes, counters and result register
`default_nettype none

module deq_ctrl #(
	parameter int QUEUE_DEPTH = deq_pkg::DEQ_QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire deq_pkg::req_t      req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output deq_pkg::rsp_t           rsp,
	input  wire deq_pkg::entry_t    head_entry,
	output deq_pkg::cell_ctl_t      ctl,
	output deq_pkg::entry_t         new_entry
);
	import deq_pkg::*;

	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [OW-1:0] DEPTH_C = OW'(QUEUE_DEPTH);
	localparam logic [OW-1:0] ONE_C   = OW'(1);

	state_t          state_q, state_d;
	logic [OW-1:0]   occ_q, occ_d;
	logic [31:0]     id_q, id_d;
	logic [30:0]     now_q, now_d;
	logic [OW-1:0]   cnt_q, cnt_d;
	logic [OW-1:0]   due_cnt_q, due_cnt_d;
	logic [OW-1:0]   emit_cnt_q, emit_cnt_d;
	logic            out_valid_q;
	rsp_t            out_q;

	logic            out_free;
	logic            out_load;
	rsp_t            out_next;
	logic            accept;
	logic            head_due;
	logic            step_ok;
	logic [14:0]     dly;
	logic [31:0]     due_sum;
	logic [30:0]     due_new;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || ((req.mode == MODE_SCHEDULE) && !out_free);
	assign accept    = req_valid && !req_stall;
	assign head_due  = head_entry.due <= now_q;
	assign step_ok   = !head_due || out_free;

	// delay below one counts as one, sum saturates at the step maximum
	assign dly     = (req.delay_steps[15] || (req.delay_steps == 16'sd0)) ?
		15'd1 : req.delay_steps[14:0];
	assign due_sum = {1'b0, req.current_step} + {17'd0, dly};
	assign due_new = due_sum[31] ? STEP_MAX : due_sum[30:0];

	assign new_entry.id       = id_q;
	assign new_entry.due      = due_new;
	assign new_entry.source   = req.source_tag;
	assign new_entry.payload  = req.payload;
	assign new_entry.external = req.is_external;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			id_q        <= FIRST_ID;
			now_q       <= '0;
			cnt_q       <= '0;
			due_cnt_q   <= '0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			occ_q      <= occ_d;
			id_q       <= id_d;
			now_q      <= now_d;
			cnt_q      <= cnt_d;
			due_cnt_q  <= due_cnt_d;
			emit_cnt_q <= emit_cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	always_comb begin
		state_d    = state_q;
		occ_d      = occ_q;
		id_d       = id_q;
		now_d      = now_q;
		cnt_d      = cnt_q;
		due_cnt_d  = due_cnt_q;
		emit_cnt_d = emit_cnt_q;
		ctl        = '0;
		out_load   = 1'b0;
		out_next   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.mode)
						MODE_SCHEDULE: begin
							out_load = 1'b1;
							if (occ_q == DEPTH_C) begin
								out_next.kind          = KIND_FULL;
								out_next.last          = 1'b1;
								out_next.pending_count = 5'(occ_q);
							end else begin
								ctl.load                = 1'b1;
								occ_d                   = OW'(occ_q + ONE_C);
								id_d                    = id_q + 32'd1;
								out_next.kind           = KIND_ECHO;
								out_next.eff_id         = id_q;
								out_next.step_stamp     = req.current_step;
								out_next.due_at         = due_new;
								out_next.out_source_tag = req.source_tag;
								out_next.out_payload    = req.payload;
								out_next.out_external   = req.is_external;
								out_next.last           = 1'b1;
								out_next.pending_count  = 5'(OW'(occ_q + ONE_C));
							end
						end
						MODE_TICK: begin
							now_d     = req.current_step;
							cnt_d     = occ_q;
							due_cnt_d = '0;
							if (occ_q != '0) begin
								state_d = ST_SCAN;
							end
						end
						MODE_CLEAR: begin
							ctl.clear = 1'b1;
							occ_d     = '0;
							id_d      = FIRST_ID;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				// rotate every entry once to count the due ones
				ctl.shift     = 1'b1;
				ctl.keep_head = 1'b1;
				due_cnt_d     = OW'(due_cnt_q + OW'(head_due));
				cnt_d         = OW'(cnt_q - ONE_C);
				if (cnt_q == ONE_C) begin
					if (due_cnt_d == '0) begin
						state_d = ST_IDLE;
					end else begin
						state_d    = ST_EMIT;
						cnt_d      = occ_q;
						emit_cnt_d = '0;
					end
				end
			end
			ST_EMIT: begin
				// pop the head, send due ones out, requeue the rest at the tail
				if (step_ok) begin
					ctl.shift     = 1'b1;
					ctl.keep_head = !head_due;
					cnt_d         = OW'(cnt_q - ONE_C);
					if (head_due) begin
						out_load                = 1'b1;
						emit_cnt_d              = OW'(emit_cnt_q + ONE_C);
						out_next.kind           = KIND_APPLY;
						out_next.eff_id         = head_entry.id;
						out_next.step_stamp     = now_q;
						out_next.due_at         = head_entry.due;
						out_next.out_source_tag = head_entry.source;
						out_next.out_payload    = head_entry.payload;
						out_next.out_external   = head_entry.external;
						out_next.last           = OW'(emit_cnt_q + ONE_C) == due_cnt_q;
						out_next.pending_count  = 5'(OW'(occ_q - due_cnt_q));
					end
					if (cnt_q == ONE_C) begin
						occ_d   = OW'(occ_q - due_cnt_q);
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_C)
		else $error("occupancy beyond queue depth");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_EMIT) |-> (cnt_q != '0 && due_cnt_q <= occ_q))
		else $error("tick pass counters out of range");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (emit_cnt_q < due_cnt_q || emit_cnt_q == due_cnt_q))
		else $error("more due entries sent than counted");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && cnt_q == ONE_C && step_ok) |=> (emit_cnt_q == due_cnt_q))
		else $error("tick ended before all due entries were sent");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.mode == MODE_SCHEDULE && occ_q == DEPTH_C) |=>
		(rsp_valid && rsp.kind == KIND_FULL && $stable(occ_q) && $stable(id_q)))
		else $error("full table changed state on schedule");

endmodule

`default_nettype wire

### sv/delayed_effect_queue.sv
// top level of the delayed effect queue: entry chain and sequencer
// Usage:
//   req channel: one beat per command (schedule, tick, clear); mode 3 is ignored.
//   rsp channel: one beat per result; last marks the final beat of a command.
//   A schedule gives one beat (echo, or full rejection) in the cycle after it is
//   taken; tick, clear and mode 3 give no beat except the due entries of a tick.
//   Entries live in a chain of QUEUE_DEPTH cells, kept packed from cell 0 in
//   insertion order. A tick makes two passes over the occupied cells, one cell
//   per cycle unless the emit pass waits on a stalled result: a counting pass,
//   then, if anything is due, a pass that sends due entries from the head and
//   moves the others back to the tail. A tick holds the block until it ends.
//   The result sits in an output register: a schedule is taken while it waits
//   unless the receiver stalls; a stalled beat holds, and the emit pass waits.
//   Reset empties the table, sets the next id to 1 and drops any pending beat.
`default_nettype none

module delayed_effect_queue #(
	parameter int QUEUE_DEPTH = deq_pkg::DEQ_QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire deq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output deq_pkg::rsp_t      rsp
);
	import deq_pkg::*;

	cell_ctl_t ctl;
	entry_t    new_entry;
	logic      cell_valid [QUEUE_DEPTH];
	entry_t    cell_entry [QUEUE_DEPTH];

	deq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.head_entry (cell_entry[0]),
		.ctl        (ctl),
		.new_entry  (new_entry)
	);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   prev_valid;
		logic   next_valid;
		entry_t next_entry;

		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_mid
			assign prev_valid = cell_valid[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_valid = 1'b0;
			assign next_entry = cell_entry[i];
		end else begin : g_inner
			assign next_valid = cell_valid[i+1];
			assign next_entry = cell_entry[i+1];
		end

		deq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (prev_valid),
			.next_valid (next_valid),
			.next_entry (next_entry),
			.head_entry (cell_entry[0]),
			.new_entry  (new_entry),
			.valid      (cell_valid[i]),
			.entry      (cell_entry[i])
		);
	end

endmodule

`default_nettype wire

### tb/delayed_effect_queue_tb.sv
// self-checking testbench for the delayed effect queue with a scoreboard class
`default_nettype none

module delayed_effect_queue_tb;
	import deq_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 2 * DEQ_QUEUE_DEPTH + 8;
	localparam int DRAIN_LIMIT = 20000;
	localparam int PHASE_ITEMS = 78;
	localparam longint TIMEOUT_CYCLES = 1000000;

	class effect_scoreboard;
		entry_t entries[$];
		rsp_t owed_results[$];
		logic [31:0] next_id;
		int errors;
		int checked;
		int commands;
		int ticks;
		int clears;
		int rejections;
		int widest_burst;

		function new();
			next_id = FIRST_ID;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		function void note_request(req_t r);
			rsp_t res;
			entry_t fresh;
			entry_t kept[$];
			rsp_t burst[$];
			int span;
			longint reach;
			if (r.mode != MODE_UNUSED) begin
				commands++;
			end
			case (r.mode)
				MODE_SCHEDULE: begin
					res = '0;
					if (entries.size() >= DEQ_QUEUE_DEPTH) begin
						res.kind = KIND_FULL;
						rejections++;
					end else begin
						span = $signed(r.delay_steps);
						if (span < 1) begin
							span = 1;
						end
						reach = longint'(r.current_step) + span;
						if (reach > longint'(STEP_MAX)) begin
							reach = longint'(STEP_MAX);
						end
						fresh.id = next_id;
						fresh.due = reach[30:0];
						fresh.source = r.source_tag;
						fresh.payload = r.payload;
						fresh.external = r.is_external;
						entries = {entries, fresh};
						res.kind = KIND_ECHO;
						res.eff_id = next_id;
						res.step_stamp = r.current_step;
						res.due_at = fresh.due;
						res.out_source_tag = r.source_tag;
						res.out_payload = r.payload;
						res.out_external = r.is_external;
						next_id = next_id + 32'd1;
					end
					res.last = 1'b1;
					res.pending_count = 5'(entries.size());
					owed_results = {owed_results, res};
				end
				MODE_TICK: begin
					ticks++;
					foreach (entries[i]) begin
						if (entries[i].due <= r.current_step) begin
							res = '0;
							res.kind = KIND_APPLY;
							res.eff_id = entries[i].id;
							res.step_stamp = r.current_step;
							res.due_at = entries[i].due;
							res.out_source_tag = entries[i].source;
							res.out_payload = entries[i].payload;
							res.out_external = entries[i].external;
							burst = {burst, res};
						end else begin
							kept = {kept, entries[i]};
						end
					end
					entries = kept;
					foreach (burst[k]) begin
						res = burst[k];
						res.pending_count = 5'(entries.size());
						res.last = (k == burst.size() - 1);
						owed_results = {owed_results, res};
					end
					if (burst.size() > widest_burst) begin
						widest_burst = burst.size();
					end
				end
				MODE_CLEAR: begin
					clears++;
					entries.delete();
					next_id = FIRST_ID;
				end
				default: begin
				end
			endcase
		endfunction

		task check_result(rsp_t got);
			rsp_t want;
			string bad;
			if (owed_results.size() == 0) begin
				report($sformatf("result with nothing owed: kind %0d id %0d", got.kind,
					got.eff_id));
				return;
			end
			want = owed_results.pop_front();
			checked++;
			bad = "";
			if (got.kind !== want.kind) bad = {bad, " kind"};
			if (got.eff_id !== want.eff_id) bad = {bad, " eff_id"};
			if (got.step_stamp !== want.step_stamp) bad = {bad, " step_stamp"};
			if (got.due_at !== want.due_at) bad = {bad, " due_at"};
			if (got.out_source_tag !== want.out_source_tag) bad = {bad, " out_source_tag"};
			if (got.out_payload !== want.out_payload) bad = {bad, " out_payload"};
			if (got.out_external !== want.out_external) bad = {bad, " out_external"};
			if (got.last !== want.last) bad = {bad, " last"};
			if (got.pending_count !== want.pending_count) bad = {bad, " pending_count"};
			if (bad != "") begin
				report($sformatf("result %0d:%s differ, got %h want %h", checked, bad, got,
					want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int hold_left = 0;
	int unsigned sim_step = 1000;
	effect_scoreboard board = new();

	delayed_effect_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stall, or a long hold-off counted here
	always @(posedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_ack <= hold_req;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			board.check_result(rsp);
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("FAIL delayed_effect_queue");
		$finish;
	end

	function automatic req_t make_cmd(logic [1:0] mode, logic [30:0] now, logic [15:0] delay,
		logic [15:0] tag, logic [63:0] pay, logic ext);
		req_t c;
		c.mode = mode;
		c.current_step = now;
		c.delay_steps = delay;
		c.source_tag = tag;
		c.payload = pay;
		c.is_external = ext;
		return c;
	endfunction

	function automatic req_t random_command();
		int unsigned pick;
		logic [30:0] now;
		logic [15:0] delay;
		logic [1:0] mode;
		pick = $urandom_range(99);
		sim_step = sim_step + $urandom_range(3);
		now = ($urandom_range(99) < 5) ? 31'($urandom) : sim_step[30:0];
		delay = ($urandom_range(99) < 12) ? 16'($urandom) : 16'($urandom_range(1, 10));
		if (pick < 58) begin
			mode = MODE_SCHEDULE;
		end else if (pick < 92) begin
			mode = MODE_TICK;
		end else if (pick < 96) begin
			mode = MODE_CLEAR;
		end else begin
			mode = MODE_UNUSED;
		end
		return make_cmd(mode, now, delay, 16'($urandom), {$urandom, $urandom}, 1'($urandom));
	endfunction

	task automatic offer_command(req_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= c;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		board.note_request(c);
	endtask

	task automatic await_results();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		req_t c;
		int counted;
		int idle_set[4];
		int stall_set[4];
		idle_set = '{0, 47, 0, 8};
		stall_set = '{0, 0, 47, 8};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, unused mode, delay and step extremes, clear, full table
		offer_command(make_cmd(MODE_TICK, 31'd0, 16'd0, 16'd0, 64'd0, 1'b0));
		offer_command(make_cmd(MODE_UNUSED, STEP_MAX, 16'hffff, 16'hffff, '1, 1'b1));
		offer_command(make_cmd(MODE_SCHEDULE, 31'd0, 16'd0, 16'h0000, 64'd0, 1'b0));
		offer_command(make_cmd(MODE_SCHEDULE, 31'd0, 16'h8000, 16'hffff, '1, 1'b1));
		offer_command(make_cmd(MODE_SCHEDULE, 31'd5, 16'h7fff, 16'h1234,
			64'h0123_4567_89ab_cdef, 1'b0));
		offer_command(make_cmd(MODE_SCHEDULE, STEP_MAX, 16'd1, 16'h8001,
			64'h8000_0000_0000_0001, 1'b1));
		offer_command(make_cmd(MODE_SCHEDULE, STEP_MAX - 31'd10, 16'd100, 16'haaaa,
			64'h5555_aaaa_5555_aaaa, 1'b0));
		offer_command(make_cmd(MODE_TICK, 31'd1, 16'd0, 16'd0, 64'd0, 1'b0));
		offer_command(make_cmd(MODE_CLEAR, 31'd2, 16'd0, 16'd0, 64'd0, 1'b0));
		for (int i = 0; i < DEQ_QUEUE_DEPTH + 1; i++) begin
			offer_command(make_cmd(MODE_SCHEDULE, 31'd100, 16'($urandom_range(1, 3)),
				16'($urandom), {$urandom, $urandom}, 1'($urandom)));
		end
		offer_command(make_cmd(MODE_TICK, STEP_MAX, 16'd0, 16'd0, 64'd0, 1'b0));
		await_results();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				c = random_command();
				offer_command(c);
				if (c.mode != MODE_UNUSED) begin
					counted++;
				end
			end
			await_results();
			if (p == 0) begin
				// long receiver hold-off while the sender keeps pushing
				stall_pct = 47;
				hold_req <= ~hold_req;
				repeat (DEQ_QUEUE_DEPTH + 2) begin
					offer_command(make_cmd(MODE_SCHEDULE, sim_step[30:0],
						16'($urandom_range(1, 4)), 16'($urandom), {$urandom, $urandom},
						1'($urandom)));
				end
				offer_command(make_cmd(MODE_TICK, sim_step[30:0] + 31'd8, 16'd0, 16'd0,
					64'd0, 1'b0));
				await_results();
			end
		end

		if (board.pending() != 0) begin
			board.report($sformatf("%0d results never arrived", board.pending()));
		end
		$display("covered %0d commands: %0d ticks, %0d clears, %0d full rejections",
			board.commands, board.ticks, board.clears, board.rejections);
		$display("checked %0d results, largest tick burst %0d, %0d mismatches",
			board.checked, board.widest_burst, board.errors);
		if (board.errors == 0) begin
			$display("PASS delayed_effect_queue");
		end else begin
			$display("FAIL delayed_effect_queue");
		end
		$finish;
	end

endmodule

`default_nettype wire
